[design/sdes_pkg.sv]
// Package for the simplified DES block cipher unit.
// Holds the subkey type, the S-box tables and the fixed bit permutations.
// Depends on nothing; every design file references it by scoped names.
`timescale 1ns / 1ps

package sdes_pkg;

  localparam int unsigned KeyW   = 10;
  localparam int unsigned BlockW = 8;
  localparam int unsigned HalfW  = 4;

  typedef logic [KeyW-1:0]   key_t;
  typedef logic [BlockW-1:0] block_t;
  typedef logic [HalfW-1:0]  half_t;

  typedef struct packed {
    block_t k1;
    block_t k2;
  } subkeys_t;

  typedef enum logic {
    REQ_ENCRYPT = 1'b0,
    REQ_DECRYPT = 1'b1
  } req_type_e;

  // Entries are indexed by {row, column}, row first.
  localparam logic [1:0] SBOX0 [16] = '{
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd3, 2'd2, 2'd1, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd3,
    2'd3, 2'd1, 2'd3, 2'd2
  };

  localparam logic [1:0] SBOX1 [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd0,
    2'd2, 2'd1, 2'd0, 2'd3
  };

  function automatic key_t perm_p10(key_t v);
    return {v[7], v[5], v[8], v[3], v[6], v[0], v[9], v[1], v[2], v[4]};
  endfunction

  function automatic block_t perm_p8(key_t v);
    return {v[4], v[7], v[3], v[6], v[2], v[5], v[0], v[1]};
  endfunction

  function automatic block_t perm_ip(block_t v);
    return {v[6], v[2], v[5], v[7], v[4], v[0], v[3], v[1]};
  endfunction

  function automatic block_t perm_ip_inv(block_t v);
    return {v[4], v[7], v[5], v[3], v[1], v[6], v[0], v[2]};
  endfunction

  function automatic block_t perm_ep(half_t v);
    return {v[0], v[3], v[2], v[1], v[2], v[1], v[0], v[3]};
  endfunction

  function automatic half_t perm_p4(half_t v);
    return {v[2], v[0], v[1], v[3]};
  endfunction

endpackage

[design/sdes_key_sched.sv]
// Key register and subkey derivation for the simplified DES unit.
// Holds the 10-bit master key written over the configuration channel.
// Depends on sdes_pkg for the P10 and P8 permutations and the subkey type.
`timescale 1ns / 1ps

module sdes_key_sched (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              key_we_i,
  input  sdes_pkg::key_t    key_i,
  output sdes_pkg::subkeys_t subkeys_o
);

  sdes_pkg::key_t key_q;
  sdes_pkg::key_t key_p10;
  logic [4:0]     hi1;
  logic [4:0]     lo1;
  logic [4:0]     hi3;
  logic [4:0]     lo3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (key_we_i) begin
      key_q <= key_i;
    end
  end

  always_comb begin
    key_p10      = sdes_pkg::perm_p10(key_q);
    hi1          = {key_p10[8:5], key_p10[9]};
    lo1          = {key_p10[3:0], key_p10[4]};
    hi3          = {hi1[2:0], hi1[4:3]};
    lo3          = {lo1[2:0], lo1[4:3]};
    subkeys_o.k1 = sdes_pkg::perm_p8({hi1, lo1});
    subkeys_o.k2 = sdes_pkg::perm_p8({hi3, lo3});
  end

endmodule

[design/sdes_round_f.sv]
// Round function F of the simplified DES unit.
// Expands a 4-bit half, mixes in a subkey, applies S0 and S1, then P4.
// Depends on sdes_pkg for the permutations and S-box tables.
`timescale 1ns / 1ps

module sdes_round_f (
  input  sdes_pkg::half_t  half_i,
  input  sdes_pkg::block_t subkey_i,
  output sdes_pkg::half_t  f_o
);

  sdes_pkg::block_t mix;
  logic [1:0]       s0;
  logic [1:0]       s1;

  always_comb begin
    mix = sdes_pkg::perm_ep(half_i) ^ subkey_i;
    s0  = sdes_pkg::SBOX0[{mix[7], mix[4], mix[6:5]}];
    s1  = sdes_pkg::SBOX1[{mix[3], mix[0], mix[2:1]}];
    f_o = sdes_pkg::perm_p4({s0, s1});
  end

endmodule

[design/simplified_des_block_cipher_unit.sv]
// Top level of the simplified DES block cipher unit.
// Instantiates sdes_key_sched and two sdes_round_f rounds; uses sdes_pkg.
//
// Usage: the input channel (in_valid_i, in_stall_o) carries one 8-bit block
// and a request type per transaction: encrypt uses the subkeys K1 then K2,
// decrypt uses K2 then K1. The output channel (out_valid_o, out_stall_i)
// returns one 8-bit block per input transaction, in order.
// The key is written over the configuration channel (cfg_valid_i,
// cfg_ready_o, cfg_data_i); cfg_ready_o is always high. The key must only
// be changed while no transaction is in flight.
// The result passes through the input register, then through both rounds
// combinationally into the output register. The unit takes one block per
// clock cycle while the receiver does not stall.
// Reset clears the key to zero and empties both register stages.
// When the receiver stalls, the result holds in the output register and
// the input register takes one more transaction if it is empty, then
// in_stall_o rises; the pipeline resumes at full rate once the stall is released.
`timescale 1ns / 1ps

module simplified_des_block_cipher_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [9:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [7:0] data_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_out_o
);

  sdes_pkg::subkeys_t subkeys;
  sdes_pkg::req_type_e req_q;
  sdes_pkg::block_t   data_q;
  sdes_pkg::block_t   result_q;
  sdes_pkg::block_t   result_d;
  sdes_pkg::block_t   key_a;
  sdes_pkg::block_t   key_b;
  sdes_pkg::block_t   init_perm;
  sdes_pkg::half_t    left_1;
  sdes_pkg::half_t    right_2;
  sdes_pkg::half_t    f_1;
  sdes_pkg::half_t    f_2;
  logic               in_vld_q;
  logic               out_vld_q;
  logic               in_load;
  logic               out_load;

  assign cfg_ready_o = 1'b1;

  sdes_key_sched u_key_sched (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_we_i  (cfg_valid_i),
    .key_i     (cfg_data_i),
    .subkeys_o (subkeys)
  );

  assign out_load   = !out_vld_q || !out_stall_i;
  assign in_load    = !in_vld_q || out_load;
  assign in_stall_o = !in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_vld_q <= in_valid_i;
      end
      if (out_load) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      req_q  <= sdes_pkg::req_type_e'(req_type_i);
      data_q <= data_in_i;
    end
    if (out_load && in_vld_q) begin
      result_q <= result_d;
    end
  end

  always_comb begin
    if (req_q == sdes_pkg::REQ_DECRYPT) begin
      key_a = subkeys.k2;
      key_b = subkeys.k1;
    end else begin
      key_a = subkeys.k1;
      key_b = subkeys.k2;
    end
    init_perm = sdes_pkg::perm_ip(data_q);
  end

  sdes_round_f u_round_1 (
    .half_i   (init_perm[3:0]),
    .subkey_i (key_a),
    .f_o      (f_1)
  );

  assign left_1 = init_perm[7:4] ^ f_1;

  sdes_round_f u_round_2 (
    .half_i   (left_1),
    .subkey_i (key_b),
    .f_o      (f_2)
  );

  assign right_2  = init_perm[3:0] ^ f_2;
  assign result_d = sdes_pkg::perm_ip_inv({right_2, left_1});

  assign out_valid_o = out_vld_q;
  assign data_out_o  = result_q;

endmodule

[test/tb.sv]
// Self-checking testbench for simplified_des_block_cipher_unit.
// Runs a directed table, then random phases, against a bit-level S-DES predictor.
// Depends on sdes_pkg and the top level of the design.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 120;
  localparam int unsigned PhaseItems    = 305;
  localparam int unsigned NumDirected   = 20;

  // Permutation tables: one nibble per entry, first entry at the top,
  // each naming a source bit counted from the most significant end.
  localparam logic [39:0] P10Tab  = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd10, 4'd1, 4'd9,
                                     4'd8, 4'd6};
  localparam logic [39:0] P8Tab   = {4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9, 8'd0};
  localparam logic [39:0] IpTab   = {4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7, 8'd0};
  localparam logic [39:0] IpInvTab = {4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6, 8'd0};
  localparam logic [39:0] EpTab   = {4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1, 8'd0};
  localparam logic [39:0] P4Tab   = {4'd2, 4'd4, 4'd3, 4'd1, 24'd0};

  // S-box entries in row-major order, first entry at the top.
  localparam logic [31:0] Sbox0Tab = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
                                      2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
  localparam logic [31:0] Sbox1Tab = {2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                                      2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

  typedef struct packed {
    sdes_pkg::key_t      key;
    sdes_pkg::req_type_e rt;
    sdes_pkg::block_t    blk;
    logic                known;
    sdes_pkg::block_t    want;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [9:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       req_type_i;
  logic [7:0] data_in_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] data_out_o;

  sdes_pkg::key_t   key_shadow;
  sdes_pkg::block_t cipher_q[$];
  int unsigned      error_count;
  int unsigned      stuck_cycles;
  bit               tx_idling;
  bit               rx_idling;
  bit               hold_off_req;
  bit               in_hold;

  // Known-answer rows use the textbook key 1010000010 and plaintext 10010111.
  stim_row_t directed [NumDirected] = '{
    '{10'h000, sdes_pkg::REQ_ENCRYPT, 8'h00, 1'b0, 8'h00},
    '{10'h000, sdes_pkg::REQ_ENCRYPT, 8'hFF, 1'b0, 8'h00},
    '{10'h000, sdes_pkg::REQ_DECRYPT, 8'h00, 1'b0, 8'h00},
    '{10'h000, sdes_pkg::REQ_DECRYPT, 8'hFF, 1'b0, 8'h00},
    '{10'h000, sdes_pkg::REQ_ENCRYPT, 8'h5A, 1'b0, 8'h00},
    '{10'h000, sdes_pkg::REQ_DECRYPT, 8'hA5, 1'b0, 8'h00},
    '{10'h3FF, sdes_pkg::REQ_ENCRYPT, 8'h00, 1'b0, 8'h00},
    '{10'h3FF, sdes_pkg::REQ_ENCRYPT, 8'hFF, 1'b0, 8'h00},
    '{10'h3FF, sdes_pkg::REQ_DECRYPT, 8'h00, 1'b0, 8'h00},
    '{10'h3FF, sdes_pkg::REQ_DECRYPT, 8'hFF, 1'b0, 8'h00},
    '{10'h282, sdes_pkg::REQ_ENCRYPT, 8'h97, 1'b1, 8'h38},
    '{10'h282, sdes_pkg::REQ_DECRYPT, 8'h38, 1'b1, 8'h97},
    '{10'h282, sdes_pkg::REQ_ENCRYPT, 8'h00, 1'b0, 8'h00},
    '{10'h282, sdes_pkg::REQ_DECRYPT, 8'hFF, 1'b0, 8'h00},
    '{10'h155, sdes_pkg::REQ_ENCRYPT, 8'h55, 1'b0, 8'h00},
    '{10'h155, sdes_pkg::REQ_DECRYPT, 8'hAA, 1'b0, 8'h00},
    '{10'h2AA, sdes_pkg::REQ_ENCRYPT, 8'h01, 1'b0, 8'h00},
    '{10'h2AA, sdes_pkg::REQ_DECRYPT, 8'h80, 1'b0, 8'h00},
    '{10'h001, sdes_pkg::REQ_ENCRYPT, 8'h7E, 1'b0, 8'h00},
    '{10'h200, sdes_pkg::REQ_DECRYPT, 8'h81, 1'b0, 8'h00}
  };

  simplified_des_block_cipher_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .data_in_i  (data_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .data_out_o (data_out_o)
  );

  function automatic logic [9:0] permute_bits(logic [9:0] v, int in_w, int out_w,
                                              logic [39:0] tab);
    logic [9:0] r;
    int         src;
    r = '0;
    for (int i = 0; i < out_w; i++) begin
      src = int'(tab[39-4*i -: 4]);
      r = {r[8:0], v[in_w-src]};
    end
    return r;
  endfunction

  function automatic logic [1:0] sbox_out(logic [31:0] tab, sdes_pkg::half_t nib);
    int idx;
    idx = int'({nib[3], nib[0], nib[2:1]});
    return tab[31-2*idx -: 2];
  endfunction

  function automatic logic [4:0] rot5(logic [4:0] v);
    return {v[3:0], v[4]};
  endfunction

  function automatic sdes_pkg::half_t mix_half(sdes_pkg::half_t h, sdes_pkg::block_t subkey);
    logic [9:0]       wide;
    sdes_pkg::block_t x;
    sdes_pkg::half_t  s;
    wide = permute_bits({6'b0, h}, 4, 8, EpTab);
    x = wide[7:0] ^ subkey;
    s = {sbox_out(Sbox0Tab, x[7:4]), sbox_out(Sbox1Tab, x[3:0])};
    wide = permute_bits({6'b0, s}, 4, 4, P4Tab);
    return wide[3:0];
  endfunction

  function automatic sdes_pkg::block_t sdes_crypt(sdes_pkg::key_t key,
                                                  sdes_pkg::req_type_e rt,
                                                  sdes_pkg::block_t blk);
    logic [9:0]       p;
    logic [4:0]       hi;
    logic [4:0]       lo;
    sdes_pkg::block_t k1;
    sdes_pkg::block_t k2;
    sdes_pkg::block_t ka;
    sdes_pkg::block_t kb;
    sdes_pkg::half_t  left;
    sdes_pkg::half_t  right;
    p = permute_bits(key, 10, 10, P10Tab);
    hi = rot5(p[9:5]);
    lo = rot5(p[4:0]);
    p = permute_bits({hi, lo}, 10, 8, P8Tab);
    k1 = p[7:0];
    hi = rot5(rot5(hi));
    lo = rot5(rot5(lo));
    p = permute_bits({hi, lo}, 10, 8, P8Tab);
    k2 = p[7:0];
    ka = (rt == sdes_pkg::REQ_DECRYPT) ? k2 : k1;
    kb = (rt == sdes_pkg::REQ_DECRYPT) ? k1 : k2;
    p = permute_bits({2'b0, blk}, 8, 8, IpTab);
    left = p[7:4];
    right = p[3:0];
    left = left ^ mix_half(right, ka);
    right = right ^ mix_half(left, kb);
    p = permute_bits({2'b0, right, left}, 8, 8, IpInvTab);
    return p[7:0];
  endfunction

  function automatic void flag_error(string what, sdes_pkg::block_t want,
                                     sdes_pkg::block_t got);
    if (error_count < 10) begin
      $display("ERROR at %0t: %s, expected data_out=%02h, actual data_out=%02h",
               $realtime, what, want, got);
    end
    error_count++;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cipher_q.size() == 0) begin
        flag_error("result with no transaction outstanding", 8'h00, data_out_o);
      end else if (data_out_o !== cipher_q[0]) begin
        flag_error("data_out mismatch", cipher_q[0], data_out_o);
        void'(cipher_q.pop_front());
      end else begin
        void'(cipher_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= WatchdogLimit) begin
        $display("Watchdog timeout at %0t", $realtime);
        $display("*** FAILED ***");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin : rx_side
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_block(sdes_pkg::req_type_e rt, sdes_pkg::block_t blk, logic known,
                            sdes_pkg::block_t want);
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    data_in_i  <= blk;
    in_hold = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    cipher_q.push_back(known ? want : sdes_crypt(key_shadow, rt, blk));
    @(negedge clk_i);
    if (tx_idling && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      in_hold = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    if (in_hold) begin
      in_valid_i <= 1'b0;
      in_hold = 1'b0;
    end
    while (cipher_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_key(sdes_pkg::key_t k);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= k;
    do @(posedge clk_i); while (!cfg_ready_o);
    key_shadow = k;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : main_seq
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    req_type_i   = sdes_pkg::REQ_ENCRYPT;
    data_in_i    = '0;
    key_shadow   = '0;
    error_count  = 0;
    stuck_cycles = 0;
    tx_idling    = 1'b0;
    rx_idling    = 1'b0;
    hold_off_req = 1'b0;
    in_hold      = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      if (directed[i].key != key_shadow) begin
        drain_results();
        write_key(directed[i].key);
      end
      send_block(directed[i].rt, directed[i].blk, directed[i].known, directed[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      drain_results();
      tx_idling = (p == 0 || p == 1 || p == 3);
      rx_idling = (p == 0 || p == 2 || p == 3);
      write_key((p == 5) ? sdes_pkg::key_t'(0) : sdes_pkg::key_t'($urandom_range(0, 1023)));
      if (p == 2) begin
        hold_off_req = 1'b1;
      end
      repeat (PhaseItems) begin
        send_block(sdes_pkg::req_type_e'($urandom_range(0, 1)),
                   sdes_pkg::block_t'($urandom_range(0, 255)), 1'b0, 8'h00);
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (cipher_q.size() != 0) begin
      flag_error("results never arrived", cipher_q[0], 8'h00);
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[simplified_des_block_cipher_unit.f]
design/sdes_pkg.sv
design/sdes_key_sched.sv
design/sdes_round_f.sv
design/simplified_des_block_cipher_unit.sv
test/tb.sv
